[hdl/ihex_pkg.sv]
// ----------------------------------------------------------------------------
// Intel HEX parser package
// Shared types and constants for the Intel HEX record parser.
// ----------------------------------------------------------------------------
package ihex_pkg;

   localparam int QueuePtrWidth   = 2;
   localparam int QueueDepth      = 1 << QueuePtrWidth;
   localparam int QueueCountWidth = QueuePtrWidth + 1;

   localparam logic [1:0] KindData = 2'd0;
   localparam logic [1:0] KindOk   = 2'd1;
   localparam logic [1:0] KindErr  = 2'd2;

   localparam logic [7:0] MaxRecordType = 8'd5;

   typedef struct packed {
      logic       line_end;
      logic       is_hex;
      logic [3:0] nibble;
   } token_type;

   typedef struct packed {
      logic      valid;
      token_type token;
   } slot_type;

endpackage

[hdl/ihex_if.sv]
// ----------------------------------------------------------------------------
// Intel HEX parser channels
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface ihex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       line_end;

   modport source (output valid, output ch, output line_end, input ready);
   modport sink   (input valid, input ch, input line_end, output ready);
endinterface

interface ihex_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [15:0] address;
   logic [7:0]  byte_count;
   logic [2:0]  record_type;

   modport source (output valid, output kind, output data_byte, output address,
                   output byte_count, output record_type, input ready);
   modport sink   (input valid, input kind, input data_byte, input address,
                   input byte_count, input record_type, output ready);
endinterface

[hdl/ihex_front.sv]
// ----------------------------------------------------------------------------
// Intel HEX parser front end
// Accepts characters and classifies each one as line end, hex digit or other.
// ----------------------------------------------------------------------------
module ihex_front
   import ihex_pkg::*;
(
   ihex_req_if.sink  req_if,
   input  logic      queue_full,
   output slot_type  push
);

   function automatic token_type classify(input logic [7:0] c, input logic le);
      token_type t;
      t.line_end = le;
      t.is_hex   = 1'b1;
      t.nibble   = 4'd0;
      if (c >= "0" && c <= "9") begin
         t.nibble = 4'(c - "0");
      end else if (c >= "A" && c <= "F") begin
         t.nibble = 4'(c - "A" + 8'd10);
      end else if (c >= "a" && c <= "f") begin
         t.nibble = 4'(c - "a" + 8'd10);
      end else begin
         t.is_hex = 1'b0;
      end
      return t;
   endfunction

   assign req_if.ready = !queue_full;
   assign push.valid   = req_if.valid && !queue_full;
   assign push.token   = classify(req_if.ch, req_if.line_end);

endmodule

[hdl/ihex_queue.sv]
// ----------------------------------------------------------------------------
// Intel HEX parser token queue
// Short FIFO of classified characters between the front and back ends.
// ----------------------------------------------------------------------------
module ihex_queue
   import ihex_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  slot_type push,
   output logic     full,
   output slot_type head,
   input  logic     pop
);

   token_type                  slot_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0] count_ff, count_in;
   logic                       do_push;

   assign full       = (count_ff == QueueCountWidth'(QueueDepth));
   assign do_push    = push.valid && !full;
   assign head.valid = (count_ff != '0);
   assign head.token = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.token;
      end
   end

endmodule

[hdl/ihex_back.sv]
// ----------------------------------------------------------------------------
// Intel HEX parser back end
// Runs the record state machine on classified characters and registers results.
// ----------------------------------------------------------------------------
module ihex_back
   import ihex_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  slot_type  head,
   output logic      pop,
   ihex_rsp_if.source rsp_if
);

   typedef enum logic [2:0] {
      PhStart, PhCount, PhAddr, PhType, PhData, PhCsum, PhDone, PhErr
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  high_ff, high_in;
   logic        pending_ff, pending_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] raddr_ff, raddr_in;
   logic [2:0]  rtype_ff, rtype_in;
   logic [7:0]  done_ff, done_in;
   logic [7:0]  sum_ff, sum_in;
   logic        aidx_ff, aidx_in;

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff;
   logic [7:0]  obyte_ff;
   logic [15:0] oaddr_ff;
   logic [7:0]  ocount_ff;
   logic [2:0]  otype_ff;

   logic        emit;
   logic [1:0]  emit_kind;
   logic [7:0]  emit_byte;
   logic [15:0] emit_addr;
   logic [7:0]  b;
   logic [7:0]  done_next;
   token_type   t;

   assign pop       = head.valid && (!valid_ff || rsp_if.ready);
   assign t         = head.token;
   assign b         = {high_ff, t.nibble};
   assign done_next = done_ff + 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      high_in    = high_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      raddr_in   = raddr_ff;
      rtype_in   = rtype_ff;
      done_in    = done_ff;
      sum_in     = sum_ff;
      aidx_in    = aidx_ff;
      emit       = 1'b0;
      emit_kind  = KindErr;
      emit_byte  = 8'd0;
      emit_addr  = raddr_ff;
      if (pop) begin
         if (t.line_end) begin
            emit       = (phase_ff != PhDone) && (phase_ff != PhErr);
            phase_in   = PhStart;
            high_in    = 4'd0;
            pending_in = 1'b0;
            count_in   = 8'd0;
            raddr_in   = 16'd0;
            rtype_in   = 3'd0;
            done_in    = 8'd0;
            sum_in     = 8'd0;
            aidx_in    = 1'b0;
         end else if (phase_ff == PhDone || phase_ff == PhErr) begin
            phase_in = phase_ff;
         end else if (phase_ff == PhStart) begin
            phase_in = PhCount;
         end else if (!t.is_hex) begin
            emit     = 1'b1;
            phase_in = PhErr;
         end else if (!pending_ff) begin
            high_in    = t.nibble;
            pending_in = 1'b1;
         end else begin
            pending_in = 1'b0;
            case (phase_ff)
               PhCount: begin
                  count_in = b;
                  sum_in   = sum_ff + b;
                  phase_in = PhAddr;
               end
               PhAddr: begin
                  if (!aidx_ff) begin
                     raddr_in = {b, 8'd0};
                     aidx_in  = 1'b1;
                  end else begin
                     raddr_in = raddr_ff | {8'd0, b};
                     aidx_in  = 1'b0;
                     phase_in = PhType;
                  end
                  sum_in = sum_ff + b;
               end
               PhType: begin
                  if (b > MaxRecordType) begin
                     emit     = 1'b1;
                     phase_in = PhErr;
                  end else begin
                     rtype_in = b[2:0];
                     sum_in   = sum_ff + b;
                     phase_in = (count_ff == 8'd0) ? PhCsum : PhData;
                  end
               end
               PhData: begin
                  emit      = 1'b1;
                  emit_kind = KindData;
                  emit_byte = b;
                  emit_addr = raddr_ff + {8'd0, done_ff};
                  sum_in    = sum_ff + b;
                  done_in   = done_next;
                  if (done_next == count_ff) begin
                     phase_in = PhCsum;
                  end
               end
               PhCsum: begin
                  emit = 1'b1;
                  if ((~sum_ff + 8'd1) != b) begin
                     phase_in = PhErr;
                  end else begin
                     emit_kind = KindOk;
                     phase_in  = PhDone;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
      valid_in = emit || (valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhStart;
         high_ff    <= 4'd0;
         pending_ff <= 1'b0;
         count_ff   <= 8'd0;
         raddr_ff   <= 16'd0;
         rtype_ff   <= 3'd0;
         done_ff    <= 8'd0;
         sum_ff     <= 8'd0;
         aidx_ff    <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         high_ff    <= high_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
         raddr_ff   <= raddr_in;
         rtype_ff   <= rtype_in;
         done_ff    <= done_in;
         sum_ff     <= sum_in;
         aidx_ff    <= aidx_in;
         valid_ff   <= valid_in;
      end
      if (emit) begin
         kind_ff   <= emit_kind;
         obyte_ff  <= emit_byte;
         oaddr_ff  <= emit_addr;
         ocount_ff <= count_ff;
         otype_ff  <= rtype_ff;
      end
   end

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.kind        = kind_ff;
   assign rsp_if.data_byte   = obyte_ff;
   assign rsp_if.address     = oaddr_ff;
   assign rsp_if.byte_count  = ocount_ff;
   assign rsp_if.record_type = otype_ff;

endmodule

[hdl/intel_hex_record_parser.sv]
// A result is registered once the character that causes it has passed the token
// queue; the character enters the token queue when it is transferred, and the
// parser step registers the result when it pops that character from the queue.
// Throughput: one character per cycle while the result output is not stalled.
// Reset is synchronous; it empties the token queue, drops any pending result
// and returns the parser to the start-code phase with all fields cleared.
// ----------------------------------------------------------------------------
// Intel HEX record parser
// Parses one Intel HEX record per line, one ASCII character per transfer.
// ----------------------------------------------------------------------------
module intel_hex_record_parser
   import ihex_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ihex_req_if.sink   req_if,
   ihex_rsp_if.source rsp_if
);

   slot_type push;
   slot_type head;
   logic     queue_full;
   logic     pop;

   ihex_front u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push)
   );

   ihex_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   ihex_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

   assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !req_if.ready)
      else $error("character taken while the token queue is full");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready) |-> !pop)
      else $error("parser stepped while a result is stalled");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("token popped from an empty queue");

   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.kind == KindData || rsp_if.kind == KindOk ||
                        rsp_if.kind == KindErr))
      else $error("result kind out of range");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("result pending right after reset");

endmodule
